@@ design/wss_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Word stack with search: shared definitions
// Store geometry, command and status codes, and sequencer states.
// ----------------------------------------------------------------------------
package wss_pkg;

    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = 64;

    localparam logic [1:0] CMD_PUSH   = 2'd0;
    localparam logic [1:0] CMD_POP    = 2'd1;
    localparam logic [1:0] CMD_SEARCH = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_POP    = 3'b010,
        S_SEARCH = 3'b100
    } state_t;

endpackage

@@ design/wss_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module wss_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/word_stack_with_search_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Word stack with search
// LIFO stack of 64-bit words with a sequential membership search.
// ----------------------------------------------------------------------------
// Usage:
//   A command (cmd, value) transfers at a clock edge where start is high and
//   busy is low. Each command yields one result on popped_word, found,
//   is_empty, depth_used and status, valid for exactly one cycle while done
//   is high; the receiver cannot stall it.
//   Push, unused command, push to full, pop from empty and search of an
//   empty stack show done in the cycle after the transfer, and the next
//   command may transfer in that same cycle. A pop reads the top entry
//   through the store's registered read port into state S_POP, which
//   registers popped_word and done. A search compares one stored entry
//   per cycle through a single comparator fed by the store's read port,
//   bottom up, and stops at the first match or at the top entry.
//   busy is high while a pop or search is in progress.
//   Reset clears the entry count and the sequencer; the store keeps no reset
//   value, and no word read from above the count is used.
// ----------------------------------------------------------------------------
module word_stack_with_search_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                cmd,
    input  logic [63:0]               value,
    output logic                      done,
    output logic [63:0]               popped_word,
    output logic                      found,
    output logic                      is_empty,
    output logic [6:0]                depth_used,
    output logic [1:0]                status
);

    wss_pkg::state_t                 state_reg, state_next;
    logic [wss_pkg::CNT_W-1:0]       count_reg, count_next;
    logic [wss_pkg::ADDR_W-1:0]      idx_reg, idx_next;
    logic [wss_pkg::WORD_W-1:0]      key_reg, key_next;

    logic                            done_reg, done_next;
    logic [wss_pkg::WORD_W-1:0]      popped_reg, popped_next;
    logic                            found_reg, found_next;
    logic [1:0]                      status_reg, status_next;
    logic [wss_pkg::CNT_W-1:0]       depth_reg, depth_next;

    logic                            ram_we;
    logic [wss_pkg::ADDR_W-1:0]      ram_raddr;
    logic [wss_pkg::WORD_W-1:0]      ram_rdata;
    logic [wss_pkg::CNT_W-1:0]       top_cnt;
    logic                            accept;
    logic                            full;

    assign accept  = start && (state_reg == wss_pkg::S_IDLE);
    assign full    = (count_reg == wss_pkg::CNT_W'(wss_pkg::DEPTH));
    assign top_cnt = count_reg - wss_pkg::CNT_W'(1);

    wss_ram #(
        .WIDTH(wss_pkg::WORD_W),
        .DEPTH(wss_pkg::DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[wss_pkg::ADDR_W-1:0]),
        .wdata (value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        key_next    = key_reg;
        done_next   = 1'b0;
        popped_next = popped_reg;
        found_next  = found_reg;
        status_next = status_reg;
        ram_we      = 1'b0;
        ram_raddr   = idx_reg + wss_pkg::ADDR_W'(1);

        case (state_reg)
            wss_pkg::S_IDLE:
            begin
                ram_raddr = '0;
                if (accept)
                begin
                    key_next    = value;
                    idx_next    = '0;
                    popped_next = '0;
                    found_next  = 1'b0;
                    status_next = wss_pkg::ST_OK;
                    case (cmd)
                        wss_pkg::CMD_PUSH:
                        begin
                            done_next = 1'b1;
                            if (full)
                            begin
                                status_next = wss_pkg::ST_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                count_next = count_reg + wss_pkg::CNT_W'(1);
                            end
                        end
                        wss_pkg::CMD_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = wss_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                ram_raddr  = top_cnt[wss_pkg::ADDR_W-1:0];
                                count_next = top_cnt;
                                state_next = wss_pkg::S_POP;
                            end
                        end
                        wss_pkg::CMD_SEARCH:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                state_next = wss_pkg::S_SEARCH;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            wss_pkg::S_POP:
            begin
                popped_next = ram_rdata;
                done_next   = 1'b1;
                state_next  = wss_pkg::S_IDLE;
            end
            wss_pkg::S_SEARCH:
            begin
                if (ram_rdata == key_reg)
                begin
                    found_next = 1'b1;
                    done_next  = 1'b1;
                    state_next = wss_pkg::S_IDLE;
                end
                else if ({1'b0, idx_reg} == top_cnt)
                begin
                    done_next  = 1'b1;
                    state_next = wss_pkg::S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + wss_pkg::ADDR_W'(1);
                end
            end
            default:
            begin
                state_next = wss_pkg::S_IDLE;
            end
        endcase

        depth_next = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wss_pkg::S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        key_reg    <= key_next;
        popped_reg <= popped_next;
        found_reg  <= found_next;
        status_reg <= status_next;
        if (done_next)
        begin
            depth_reg <= depth_next;
        end
    end

    assign busy        = (state_reg != wss_pkg::S_IDLE);
    assign done        = done_reg;
    assign popped_word = popped_reg;
    assign found       = found_reg;
    assign is_empty    = (depth_reg == '0);
    assign depth_used  = depth_reg;
    assign status      = status_reg;

endmodule

@@ test/wss_scoreboard.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Word stack with search: scoreboard
// Watches the command and result channels of the stack, keeps a shadow copy
// of the stored words and the entry count, predicts each result and compares
// it field by field with what the block reports.
// ----------------------------------------------------------------------------
module wss_scoreboard (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic [1:0]        cmd,
    input  logic [63:0]       value,
    input  logic              done,
    input  logic [63:0]       popped_word,
    input  logic              found,
    input  logic              is_empty,
    input  logic [6:0]        depth_used,
    input  logic [1:0]        status,
    output int                errors,
    output int                pending,
    output int                full_pushes,
    output int                empty_pops,
    output int                search_hits
);

    typedef struct packed {
        logic [63:0] popped;
        logic        hit;
        logic        empty;
        logic [6:0]  used;
        logic [1:0]  code;
    } stack_result_t;

    logic [wss_pkg::WORD_W-1:0] shadow_words [wss_pkg::DEPTH];
    int unsigned                shadow_count;
    stack_result_t              expected_q [$];
    int                         err_count;
    int                         full_count;
    int                         empty_count;
    int                         hit_count;

    function automatic stack_result_t apply_command(input logic [1:0] c,
                                                    input logic [63:0] v);
        stack_result_t r;
        int unsigned   i;
        r = '0;
        case (c)
            wss_pkg::CMD_PUSH:
            begin
                if (shadow_count >= wss_pkg::DEPTH)
                    r.code = wss_pkg::ST_FULL;
                else
                begin
                    shadow_words[wss_pkg::ADDR_W'(shadow_count)] = v;
                    shadow_count++;
                end
            end
            wss_pkg::CMD_POP:
            begin
                if (shadow_count == 0)
                    r.code = wss_pkg::ST_EMPTY;
                else
                begin
                    shadow_count--;
                    r.popped = shadow_words[wss_pkg::ADDR_W'(shadow_count)];
                end
            end
            wss_pkg::CMD_SEARCH:
            begin
                for (i = 0; i < shadow_count; i++)
                    if (shadow_words[wss_pkg::ADDR_W'(i)] == v)
                        r.hit = 1'b1;
            end
            default:
            begin
            end
        endcase
        r.empty = (shadow_count == 0);
        r.used  = shadow_count[6:0];
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                     $time, name, exp_v, act_v);
            err_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        stack_result_t want;
        if (!rst_n)
        begin
            expected_q.delete();
            shadow_count = 0;
            err_count    = 0;
            full_count   = 0;
            empty_count  = 0;
            hit_count    = 0;
            errors       <= 0;
            pending      <= 0;
            full_pushes  <= 0;
            empty_pops   <= 0;
            search_hits  <= 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t ns: result with no command outstanding", $time);
                    err_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("popped_word", want.popped, popped_word);
                    check_field("found", 64'(want.hit), 64'(found));
                    check_field("is_empty", 64'(want.empty), 64'(is_empty));
                    check_field("depth_used", 64'(want.used), 64'(depth_used));
                    check_field("status", 64'(want.code), 64'(status));
                end
            end
            if (start && !busy)
            begin
                want = apply_command(cmd, value);
                if (want.code == wss_pkg::ST_FULL)
                    full_count++;
                if (want.code == wss_pkg::ST_EMPTY)
                    empty_count++;
                if (want.hit)
                    hit_count++;
                expected_q.push_back(want);
            end
            errors      <= err_count;
            pending     <= expected_q.size();
            full_pushes <= full_count;
            empty_pops  <= empty_count;
            search_hits <= hit_count;
        end
    end

endmodule

@@ test/tb_word_stack_with_search_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Word stack with search: testbench top
// Drives push, pop, search and unused commands through the start/busy
// handshake, first a directed sequence, then random fill, drain and mixed
// segments under several sender idle rates; the scoreboard checks results.
// ----------------------------------------------------------------------------
module tb_word_stack_with_search_unit;

    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam int         STALL_LIMIT  = 1000;
    localparam int         RANDOM_ITEMS = 1000;
    localparam int         SEGMENT_LEN  = 100;
    localparam int         MAX_GAP      = 20;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  cmd;
    logic [63:0] value;
    logic        done;
    logic [63:0] popped_word;
    logic        found;
    logic        is_empty;
    logic [6:0]  depth_used;
    logic [1:0]  status;

    int          errors;
    int          pending;
    int          full_pushes;
    int          empty_pops;
    int          search_hits;

    int          idle_pct;
    int          stall_cycles;
    int          sent_by_cmd [4];
    logic [63:0] word_pool [8];
    int          idle_pct_tab [4] = '{0, 52, 0, 12};

    word_stack_with_search_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .value       (value),
        .done        (done),
        .popped_word (popped_word),
        .found       (found),
        .is_empty    (is_empty),
        .depth_used  (depth_used),
        .status      (status)
    );

    wss_scoreboard u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .value       (value),
        .done        (done),
        .popped_word (popped_word),
        .found       (found),
        .is_empty    (is_empty),
        .depth_used  (depth_used),
        .status      (status),
        .errors      (errors),
        .pending     (pending),
        .full_pushes (full_pushes),
        .empty_pops  (empty_pops),
        .search_hits (search_hits)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb_word_stack_with_search_unit: errors");
            $finish;
        end
    end

    function automatic logic [63:0] pick_word();
        int sel;
        sel = $urandom_range(9);
        if (sel < 5)
            return word_pool[3'($urandom_range(7))];
        else if (sel == 5)
            return 64'd0;
        else if (sel == 6)
            return '1;
        else
            return {$urandom, $urandom};
    endfunction

    function automatic logic [1:0] pick_cmd(input int mode);
        int roll;
        roll = $urandom_range(99);
        case (mode)
            0:
            begin
                if (roll < 80)
                    return wss_pkg::CMD_PUSH;
                else if (roll < 90)
                    return wss_pkg::CMD_POP;
                else if (roll < 98)
                    return wss_pkg::CMD_SEARCH;
            end
            1:
            begin
                if (roll < 80)
                    return wss_pkg::CMD_POP;
                else if (roll < 90)
                    return wss_pkg::CMD_PUSH;
                else if (roll < 98)
                    return wss_pkg::CMD_SEARCH;
            end
            default:
            begin
                if (roll < 35)
                    return wss_pkg::CMD_PUSH;
                else if (roll < 65)
                    return wss_pkg::CMD_POP;
                else if (roll < 95)
                    return wss_pkg::CMD_SEARCH;
            end
        endcase
        return CMD_UNUSED;
    endfunction

    // Hold the command until the transfer edge, which is where this returns.
    task automatic send(input logic [1:0] c, input logic [63:0] v);
        start <= 1'b1;
        cmd   <= c;
        value <= v;
        sent_by_cmd[c]++;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic idle_gap();
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            value <= {$urandom, $urandom};
            @(posedge clk);
            gap++;
        end
    endtask

    initial
    begin
        int i;
        rst_n    = 1'b0;
        start    = 1'b0;
        cmd      = wss_pkg::CMD_PUSH;
        value    = '0;
        idle_pct = 0;
        foreach (sent_by_cmd[k])
            sent_by_cmd[k] = 0;
        foreach (word_pool[k])
            word_pool[k] = {$urandom, $urandom};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(wss_pkg::CMD_POP, '1);
        send(wss_pkg::CMD_SEARCH, 64'd0);
        send(wss_pkg::CMD_PUSH, 64'd0);
        send(wss_pkg::CMD_PUSH, '1);
        send(wss_pkg::CMD_PUSH, 64'h8000_0000_0000_0001);
        send(wss_pkg::CMD_SEARCH, 64'h8000_0000_0000_0001);
        send(wss_pkg::CMD_SEARCH, 64'd0);
        send(wss_pkg::CMD_SEARCH, '1);
        send(wss_pkg::CMD_SEARCH, 64'h5555_5555_5555_5555);
        send(CMD_UNUSED, 64'hAAAA_AAAA_AAAA_AAAA);
        send(wss_pkg::CMD_POP, 64'd0);
        send(wss_pkg::CMD_POP, 64'd0);
        send(CMD_UNUSED, 64'd0);
        send(wss_pkg::CMD_POP, 64'd0);
        send(wss_pkg::CMD_POP, '1);
        send(wss_pkg::CMD_SEARCH, '1);
        send(wss_pkg::CMD_PUSH, 64'h5555_5555_5555_5555);
        send(wss_pkg::CMD_PUSH, 64'hAAAA_AAAA_AAAA_AAAA);
        send(wss_pkg::CMD_POP, 64'd0);

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            idle_pct = idle_pct_tab[2'((i / SEGMENT_LEN) % 4)];
            idle_gap();
            send(pick_cmd((i / SEGMENT_LEN) % 3), pick_word());
        end

        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (wss_pkg::DEPTH + 4) @(posedge clk);

        $display("Sent %0d commands: %0d push, %0d pop, %0d search, %0d unused code;",
                 sent_by_cmd[0] + sent_by_cmd[1] + sent_by_cmd[2] + sent_by_cmd[3],
                 sent_by_cmd[wss_pkg::CMD_PUSH], sent_by_cmd[wss_pkg::CMD_POP],
                 sent_by_cmd[wss_pkg::CMD_SEARCH], sent_by_cmd[CMD_UNUSED]);
        $display("sender gaps 0/12/52 pct, %0d full pushes, %0d empty pops, %0d search hits.",
                 full_pushes, empty_pops, search_hits);
        if (errors == 0 && pending == 0)
            $display("tb_word_stack_with_search_unit: clean");
        else
            $display("tb_word_stack_with_search_unit: errors");
        $finish;
    end

endmodule

@@ filelist.f @@
design/wss_pkg.sv
design/wss_ram.sv
design/word_stack_with_search_unit.sv
test/wss_scoreboard.sv
test/tb_word_stack_with_search_unit.sv
